// ===== src/encoder_pid_pwm_drive_top_macros.svh =====
`ifndef ENCODER_PID_PWM_DRIVE_TOP_MACROS_SVH
`define ENCODER_PID_PWM_DRIVE_TOP_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define EPD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset.
`define EPD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/epd_pkg.sv =====
package epd_pkg;

   // Field and register widths.
   localparam int POS_W      = 13;
   localparam int CTRL_W     = 21;
   localparam int DUTY_W     = 16;
   localparam int GAIN_W     = 12;
   localparam int LIMIT_W    = 10;
   localparam int DZONE_W    = 8;
   localparam int BLANK_W    = 8;
   localparam int OGAIN_W    = 10;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 12;

   // Internal datapath widths.
   localparam int FRAC_W     = 8;
   localparam int ERR_W      = 13;
   localparam int DIFF1_W    = 14;
   localparam int DIFF2_W    = 15;
   localparam int PROD_W     = 28;
   localparam int TERM_W     = PROD_W - FRAC_W;
   localparam int SUM_W      = 22;
   localparam int MAG_W      = 21;
   localparam int DIV5_SHIFT = 22;
   localparam int QPROD_W    = 41;
   localparam int QUOT_W     = QPROD_W - DIV5_SHIFT;
   localparam int TEN_W      = 23;
   localparam int DRIVE_W    = 23;
   localparam int OFF_W      = 14;
   localparam int MAGB_W     = 11;
   localparam int DRAW_W     = MAGB_W + OGAIN_W;

   // Loop constants.
   localparam int POS_WRAP    = 4000;
   localparam int ERR_MOD     = 2000;
   localparam int SET_POINT   = 1000;
   localparam int EN_LOW      = 900;
   localparam int EN_HIGH     = 1100;
   localparam int DRIVE_BIAS  = 4000;
   localparam int CTRL_MAX    = 1048575;
   localparam int DUTY_MAX    = 65535;
   localparam int ERR_RESET   = 913;
   // ceil(2^22 / 5): exact floor division by 5 for magnitudes below 2^22.
   localparam int DIV5_RECIP  = 838861;

   localparam int RSP_DEPTH_DEF = 8;

   // Register reset values.
   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = GAIN_W'(384);
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = GAIN_W'(256);
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = GAIN_W'(333);
   localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = LIMIT_W'(350);
   localparam logic [DZONE_W-1:0] DEAD_ZONE_RST   = DZONE_W'(5);
   localparam logic [BLANK_W-1:0] BLANK_FWD_RST   = BLANK_W'(30);
   localparam logic [BLANK_W-1:0] BLANK_REV_RST   = BLANK_W'(50);
   localparam logic [OGAIN_W-1:0] OUTPUT_GAIN_RST = OGAIN_W'(256);

   typedef enum logic {
      OP_PULSE = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN     = 4'd0,
      CSR_INTEG_GAIN    = 4'd1,
      CSR_DERIV_GAIN    = 4'd2,
      CSR_DRIVE_LIMIT   = 4'd3,
      CSR_DEAD_ZONE     = 4'd4,
      CSR_BLANK_FORWARD = 4'd5,
      CSR_BLANK_REVERSE = 4'd6,
      CSR_OUTPUT_GAIN   = 4'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  position;
      logic signed [CTRL_W-1:0] control_value;
      logic [DUTY_W-1:0]        duty_forward;
      logic [DUTY_W-1:0]        duty_reverse;
      logic                     drive_enable;
   } rsp_item_type;

endpackage

// ===== src/epd_ifs.sv =====
interface req_if;
   logic valid;
   logic ready;
   logic operation;
   logic encoder_level;

   modport source (output valid, output operation, output encoder_level, input ready);
   modport sink   (input valid, input operation, input encoder_level, output ready);
endinterface

interface rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [epd_pkg::POS_W-1:0]  position;
   logic signed [epd_pkg::CTRL_W-1:0] control_value;
   logic [epd_pkg::DUTY_W-1:0]        duty_forward;
   logic [epd_pkg::DUTY_W-1:0]        duty_reverse;
   logic                              drive_enable;

   modport source (output valid, output position, output control_value,
                   output duty_forward, output duty_reverse, output drive_enable,
                   input ready);
   modport sink   (input valid, input position, input control_value,
                   input duty_forward, input duty_reverse, input drive_enable,
                   output ready);
endinterface

interface csr_if;
   logic                              valid;
   logic                              ready;
   logic [epd_pkg::CSR_IDX_W-1:0]     index;
   logic [epd_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/encoder_pid_pwm_drive_top.sv =====
// Encoder-driven velocity-form PID loop with a two-sided PWM duty output.
// The request channel (req_ch) carries one event per request: an encoder pulse,
// which steps the position up or down by the quadrature B level, or a sample
// tick, which runs one PID update. Every request produces exactly one response
// on rsp_ch with the position, control value, both duty compare values and the
// drive enable, in request order.
// The configuration channel (csr_ch) is always ready; it writes one register
// per handshake by index and should only be used while no request is pending.
// Throughput is one request per clock while req_ch.ready is high. The work
// runs through six pipeline registers, and a response is offered once its
// entry lands in the response queue. The RSP_DEPTH-entry response queue bounds
// the requests in flight; req_ch.ready drops while RSP_DEPTH requests are
// unanswered, so at the default depth of 8 the block keeps full rate with an
// always-ready receiver.
// When the receiver stalls, finished responses wait in the queue and requests
// keep being accepted until the queue's credit runs out.
// Reset (synchronous, active high) restores register defaults, zeroes the
// position, control value and duties, presets all three errors and empties the
// pipeline and queue.
module encoder_pid_pwm_drive_top #(
   parameter int RSP_DEPTH = epd_pkg::RSP_DEPTH_DEF
) (
   input  logic   clock,
   input  logic   reset,
   req_if.sink    req_ch,
   rsp_if.source  rsp_ch,
   csr_if.sink    csr_ch
);
   import epd_pkg::*;

   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic signed [POS_W-1:0] MOD_P  = POS_W'(ERR_MOD);
   localparam logic signed [POS_W-1:0] SET_P  = POS_W'(SET_POINT);
   localparam logic signed [POS_W-1:0] WRAP_P = POS_W'(POS_WRAP);

   // Truncating division by 2^FRAC_W (toward zero) of a signed product.
   function automatic logic signed [TERM_W-1:0] trunc_frac(
      input logic signed [PROD_W-1:0] p
   );
      logic signed [PROD_W-1:0] adj;
      adj = p[PROD_W-1] ? p + PROD_W'((1 << FRAC_W) - 1) : p;
      return TERM_W'(adj >>> FRAC_W);
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [GAIN_W-1:0]  prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [LIMIT_W-1:0] drive_limit_ff;
   logic [DZONE_W-1:0] dead_zone_ff;
   logic [BLANK_W-1:0] blank_fwd_ff, blank_rev_ff;
   logic [OGAIN_W-1:0] output_gain_ff;
   logic               csr_fire;

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= PROP_GAIN_RST;
         integ_gain_ff  <= INTEG_GAIN_RST;
         deriv_gain_ff  <= DERIV_GAIN_RST;
         drive_limit_ff <= DRIVE_LIMIT_RST;
         dead_zone_ff   <= DEAD_ZONE_RST;
         blank_fwd_ff   <= BLANK_FWD_RST;
         blank_rev_ff   <= BLANK_REV_RST;
         output_gain_ff <= OUTPUT_GAIN_RST;
      end else if (csr_fire) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_PROP_GAIN:     prop_gain_ff   <= csr_ch.data[GAIN_W-1:0];
            CSR_INTEG_GAIN:    integ_gain_ff  <= csr_ch.data[GAIN_W-1:0];
            CSR_DERIV_GAIN:    deriv_gain_ff  <= csr_ch.data[GAIN_W-1:0];
            CSR_DRIVE_LIMIT:   drive_limit_ff <= csr_ch.data[LIMIT_W-1:0];
            CSR_DEAD_ZONE:     dead_zone_ff   <= csr_ch.data[DZONE_W-1:0];
            CSR_BLANK_FORWARD: blank_fwd_ff   <= csr_ch.data[BLANK_W-1:0];
            CSR_BLANK_REVERSE: blank_rev_ff   <= csr_ch.data[BLANK_W-1:0];
            CSR_OUTPUT_GAIN:   output_gain_ff <= csr_ch.data[OGAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request acceptance and credit. A request is taken only when the
   // response queue is sure to have room for it when it comes out.
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0] inflight_ff, inflight_in;
   logic             req_fire, rsp_fire, is_tick;

   assign req_ch.ready = (inflight_ff < CNT_W'(RSP_DEPTH));
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_tick      = (req_ch.operation == OP_TICK);

   always_comb begin
      inflight_in = inflight_ff;
      if (req_fire && !rsp_fire) begin
         inflight_in = inflight_ff + CNT_W'(1);
      end else if (!req_fire && rsp_fire) begin
         inflight_in = inflight_ff - CNT_W'(1);
      end
   end

   // ---------------------------------------------------------------------
   // Entry stage: position counter and error history. These update as the
   // request is accepted, so the next request sees them at once.
   // ---------------------------------------------------------------------
   logic signed [POS_W-1:0]   count_ff, count_in, step_pos, rem_pos;
   logic signed [ERR_W-1:0]   err_now_ff, err_last_ff, err_before_ff, err_new;
   logic signed [DIFF1_W-1:0] diff1_in;
   logic signed [DIFF2_W-1:0] diff2_in;

   always_comb begin
      step_pos = req_ch.encoder_level ? count_ff + POS_W'(1) : count_ff - POS_W'(1);
      // The count returns to zero once its magnitude reaches the wrap point.
      if (step_pos == WRAP_P || step_pos == -WRAP_P) begin
         step_pos = '0;
      end
      count_in = is_tick ? count_ff : step_pos;

      // Signed remainder: the count never reaches twice the modulus.
      if (count_ff >= MOD_P) begin
         rem_pos = count_ff - MOD_P;
      end else if (count_ff <= -MOD_P) begin
         rem_pos = count_ff + MOD_P;
      end else begin
         rem_pos = count_ff;
      end
      err_new  = ERR_W'(rem_pos - SET_P);
      diff1_in = DIFF1_W'(err_new) - DIFF1_W'(err_now_ff);
      diff2_in = DIFF2_W'(err_new) - (DIFF2_W'(err_now_ff) <<< 1) + DIFF2_W'(err_last_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         err_now_ff    <= ERR_W'(ERR_RESET);
         err_last_ff   <= ERR_W'(ERR_RESET);
         err_before_ff <= ERR_W'(ERR_RESET);
         inflight_ff   <= '0;
      end else begin
         inflight_ff <= inflight_in;
         if (req_fire) begin
            count_ff <= count_in;
            if (is_tick) begin
               err_before_ff <= err_last_ff;
               err_last_ff   <= err_now_ff;
               err_now_ff    <= err_new;
            end
         end
      end
   end

   // Stage 1: error terms of the new sample.
   logic                      s1_valid_ff, s1_tick_ff;
   logic signed [POS_W-1:0]   s1_pos_ff;
   logic signed [ERR_W-1:0]   s1_err_ff;
   logic signed [DIFF1_W-1:0] s1_diff1_ff;
   logic signed [DIFF2_W-1:0] s1_diff2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
      if (req_fire) begin
         s1_tick_ff  <= is_tick;
         s1_pos_ff   <= count_in;
         s1_err_ff   <= err_new;
         s1_diff1_ff <= diff1_in;
         s1_diff2_ff <= diff2_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: the three gain products, one multiplier each.
   // ---------------------------------------------------------------------
   logic                     s2_valid_ff, s2_tick_ff;
   logic signed [POS_W-1:0]  s2_pos_ff;
   logic signed [PROD_W-1:0] s2_pprod_ff, s2_iprod_ff, s2_dprod_ff;
   logic signed [PROD_W-1:0] pprod_in, iprod_in, dprod_in;

   assign pprod_in = PROD_W'($signed({1'b0, prop_gain_ff}))  * PROD_W'(s1_diff1_ff);
   assign iprod_in = PROD_W'($signed({1'b0, integ_gain_ff})) * PROD_W'(s1_err_ff);
   assign dprod_in = PROD_W'($signed({1'b0, deriv_gain_ff})) * PROD_W'(s1_diff2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_tick_ff  <= s1_tick_ff;
      s2_pos_ff   <= s1_pos_ff;
      s2_pprod_ff <= pprod_in;
      s2_iprod_ff <= iprod_in;
      s2_dprod_ff <= dprod_in;
   end

   // Stage 3: each term is truncated toward zero, then summed.
   logic                    s3_valid_ff, s3_tick_ff;
   logic signed [POS_W-1:0] s3_pos_ff;
   logic signed [SUM_W-1:0] s3_sum_ff, sum_in;

   assign sum_in = SUM_W'(trunc_frac(s2_pprod_ff)) + SUM_W'(trunc_frac(s2_iprod_ff))
                 + SUM_W'(trunc_frac(s2_dprod_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_tick_ff <= s2_tick_ff;
      s3_pos_ff  <= s2_pos_ff;
      s3_sum_ff  <= sum_in;
   end

   // ---------------------------------------------------------------------
   // Stage 4: divide the magnitude by five through a reciprocal multiply.
   // The sign is reapplied afterwards, which gives truncation toward zero.
   // ---------------------------------------------------------------------
   logic                     s4_valid_ff, s4_tick_ff, s4_neg_ff, neg_in;
   logic signed [POS_W-1:0]  s4_pos_ff;
   logic [MAG_W-1:0]         sum_mag;
   logic [QPROD_W-1:0]       s4_qprod_ff, qprod_in;

   assign neg_in   = s3_sum_ff[SUM_W-1];
   assign sum_mag  = neg_in ? MAG_W'(-s3_sum_ff) : MAG_W'(s3_sum_ff);
   assign qprod_in = QPROD_W'(sum_mag) * QPROD_W'(DIV5_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_tick_ff  <= s3_tick_ff;
      s4_pos_ff   <= s3_pos_ff;
      s4_neg_ff   <= neg_in;
      s4_qprod_ff <= qprod_in;
   end

   // ---------------------------------------------------------------------
   // Stage 5: times ten, clamp, and update the control register. A pulse
   // picks up the control value left by the last tick ahead of it.
   // ---------------------------------------------------------------------
   logic                     s5_valid_ff;
   logic signed [POS_W-1:0]  s5_pos_ff;
   logic signed [CTRL_W-1:0] s5_ctrl_ff, control_ff, ctrl_in, tick_ctrl;
   logic [QUOT_W-1:0]        quot;
   logic [TEN_W-1:0]         ten_mag, ten_clip;

   always_comb begin
      quot    = s4_qprod_ff[DIV5_SHIFT +: QUOT_W];
      ten_mag = (TEN_W'(quot) << 3) + (TEN_W'(quot) << 1);
      if (ten_mag > TEN_W'(CTRL_MAX)) begin
         ten_clip = TEN_W'(CTRL_MAX);
      end else begin
         ten_clip = ten_mag;
      end
      tick_ctrl = s4_neg_ff ? -CTRL_W'(ten_clip) : CTRL_W'(ten_clip);
      ctrl_in   = s4_tick_ff ? tick_ctrl : control_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         control_ff  <= '0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
         if (s4_valid_ff) begin
            control_ff <= ctrl_in;
         end
      end
      s5_pos_ff  <= s4_pos_ff;
      s5_ctrl_ff <= ctrl_in;
   end

   // ---------------------------------------------------------------------
   // Stage 6: drive value, clamp to the limit, dead zone, add blanking.
   // ---------------------------------------------------------------------
   logic                      s6_valid_ff, s6_fwd_ff, fwd_in, dead;
   logic signed [POS_W-1:0]   s6_pos_ff;
   logic signed [CTRL_W-1:0]  s6_ctrl_ff;
   logic [MAGB_W-1:0]         s6_magb_ff, magb_in;
   logic signed [DRIVE_W-1:0] drive, drive_clip, lim_s;
   logic signed [OFF_W-1:0]   off;
   logic [OFF_W-1:0]          off_mag;
   logic [LIMIT_W-1:0]        drive_mag;

   always_comb begin
      drive = -(DRIVE_W'(s5_ctrl_ff) + DRIVE_W'(DRIVE_BIAS));
      lim_s = DRIVE_W'(drive_limit_ff);
      if (drive > lim_s) begin
         drive_clip = lim_s;
      end else if (drive < -lim_s) begin
         drive_clip = -lim_s;
      end else begin
         drive_clip = drive;
      end

      // Near the set point the drive is forced to zero, which selects the
      // forward side with zero magnitude.
      off     = OFF_W'(s5_pos_ff) + OFF_W'(SET_POINT);
      off_mag = off[OFF_W-1] ? OFF_W'(-off) : OFF_W'(off);
      dead    = (off_mag <= OFF_W'(dead_zone_ff));

      fwd_in = dead || !drive_clip[DRIVE_W-1];
      if (dead) begin
         drive_mag = '0;
      end else if (fwd_in) begin
         drive_mag = LIMIT_W'(drive_clip);
      end else begin
         drive_mag = LIMIT_W'(-drive_clip);
      end
      magb_in = MAGB_W'(drive_mag) + MAGB_W'(fwd_in ? blank_fwd_ff : blank_rev_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      s6_fwd_ff  <= fwd_in;
      s6_magb_ff <= magb_in;
      s6_pos_ff  <= s5_pos_ff;
      s6_ctrl_ff <= s5_ctrl_ff;
   end

   // ---------------------------------------------------------------------
   // Final step: duty scaling updates one side; the other side holds.
   // ---------------------------------------------------------------------
   logic [DUTY_W-1:0] duty_fwd_ff, duty_rev_ff, duty_fwd_in, duty_rev_in, duty_new;
   logic [DRAW_W-1:0] duty_raw, duty_shift;
   logic [POS_W-1:0]  pos_mag;
   rsp_item_type      item_in;

   always_comb begin
      duty_raw   = DRAW_W'(s6_magb_ff) * DRAW_W'(output_gain_ff);
      duty_shift = duty_raw >> FRAC_W;
      if (duty_shift > DRAW_W'(DUTY_MAX)) begin
         duty_new = DUTY_W'(DUTY_MAX);
      end else begin
         duty_new = DUTY_W'(duty_shift);
      end
      duty_fwd_in = s6_fwd_ff ? duty_new : duty_fwd_ff;
      duty_rev_in = s6_fwd_ff ? duty_rev_ff : duty_new;

      pos_mag = s6_pos_ff[POS_W-1] ? POS_W'(-s6_pos_ff) : POS_W'(s6_pos_ff);

      item_in.position      = s6_pos_ff;
      item_in.control_value = s6_ctrl_ff;
      item_in.duty_forward  = duty_fwd_in;
      item_in.duty_reverse  = duty_rev_in;
      item_in.drive_enable  = (pos_mag >= POS_W'(EN_LOW)) && (pos_mag <= POS_W'(EN_HIGH));
   end

   // ---------------------------------------------------------------------
   // Response queue. The credit check at the entry keeps it from filling
   // past RSP_DEPTH, so writes never need a full check.
   // ---------------------------------------------------------------------
   rsp_item_type     rsp_queue [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] fill_ff, fill_in;
   rsp_item_type     head;

   assign head     = rsp_queue[rd_ptr_ff];
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      fill_in = fill_ff;
      if (s6_valid_ff && !rsp_fire) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (!s6_valid_ff && rsp_fire) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_fwd_ff <= '0;
         duty_rev_ff <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fill_ff     <= '0;
      end else begin
         fill_ff <= fill_in;
         if (s6_valid_ff) begin
            duty_fwd_ff <= duty_fwd_in;
            duty_rev_ff <= duty_rev_in;
            wr_ptr_ff   <= (wr_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s6_valid_ff) begin
         rsp_queue[wr_ptr_ff] <= item_in;
      end
   end

   assign rsp_ch.valid         = (fill_ff != '0);
   assign rsp_ch.position      = head.position;
   assign rsp_ch.control_value = head.control_value;
   assign rsp_ch.duty_forward  = head.duty_forward;
   assign rsp_ch.duty_reverse  = head.duty_reverse;
   assign rsp_ch.drive_enable  = head.drive_enable;

endmodule

// ===== src/epd_chk.sv =====
`include "encoder_pid_pwm_drive_top_macros.svh"

module epd_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [epd_pkg::POS_W-1:0]  rsp_position,
   input logic signed [epd_pkg::CTRL_W-1:0] rsp_control_value,
   input logic [epd_pkg::DUTY_W-1:0]        rsp_duty_forward,
   input logic [epd_pkg::DUTY_W-1:0]        rsp_duty_reverse,
   input logic                              rsp_drive_enable
);
   import epd_pkg::*;

   localparam int OUT_W = 16;
   localparam logic signed [POS_W-1:0] WRAP_P = POS_W'(POS_WRAP);
   localparam logic signed [POS_W-1:0] LOW_P  = POS_W'(EN_LOW);
   localparam logic signed [POS_W-1:0] HIGH_P = POS_W'(EN_HIGH);

   logic [OUT_W-1:0] outstanding_ff;
   logic             in_window;
   rsp_item_type     rsp_payload;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + OUT_W'(req_valid && req_ready)
                         - OUT_W'(rsp_valid && rsp_ready);
      end
   end

   assign in_window = (rsp_position >= LOW_P && rsp_position <= HIGH_P)
                   || (rsp_position <= -LOW_P && rsp_position >= -HIGH_P);

   assign rsp_payload.position      = rsp_position;
   assign rsp_payload.control_value = rsp_control_value;
   assign rsp_payload.duty_forward  = rsp_duty_forward;
   assign rsp_payload.duty_reverse  = rsp_duty_reverse;
   assign rsp_payload.drive_enable  = rsp_drive_enable;

   // A stalled response stays offered and unchanged.
   `EPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response changed while stalled")

   // Every response answers a request that was accepted earlier.
   `EPD_ASSERT_NOW(a_rsp_has_req, rsp_valid, outstanding_ff != '0, "response without a pending request")

   // The reported position always lies inside the wrap range.
   `EPD_ASSERT_NOW(a_pos_range, rsp_valid, rsp_position < WRAP_P && rsp_position > -WRAP_P, "position outside wrap range")

   // The enable flag follows the position window of the same response.
   `EPD_ASSERT_NOW(a_enable_window, rsp_valid, rsp_drive_enable == in_window, "drive enable disagrees with position")

endmodule

bind encoder_pid_pwm_drive_top epd_chk u_epd_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_position      (rsp_ch.position),
   .rsp_control_value (rsp_ch.control_value),
   .rsp_duty_forward  (rsp_ch.duty_forward),
   .rsp_duty_reverse  (rsp_ch.duty_reverse),
   .rsp_drive_enable  (rsp_ch.drive_enable)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import epd_pkg::*;

   // The control sum is divided by five and then scaled by ten.
   localparam int CTRL_DIV      = 5;
   localparam int CTRL_MUL      = 10;
   localparam int IDLE_PCT      = 35;
   // Settling time after the last response; this is ample.
   localparam int SETTLE_CYCLES = 16;
   localparam int STALL_CYCLES  = 300;
   localparam int CYCLE_LIMIT   = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   req_if req_ch();
   rsp_if rsp_ch();
   csr_if csr_ch();

   encoder_pid_pwm_drive_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Loop state as the block should hold it.
   int     enc_pos;
   int     err_now, err_last, err_before;
   longint control_now;
   int     duty_fwd, duty_rev;

   // Register copies, already masked to their widths.
   int prop_gain, integ_gain, deriv_gain, drive_limit;
   int dead_zone, blank_fwd, blank_rev, output_gain;

   // Responses predicted at request acceptance, oldest first.
   rsp_item_type pending_rsp[$];

   int  fail_count;
   int  cycle_count;
   int  pulse_count, tick_count, write_count, rsp_count;
   int  wrap_count, enabled_count;
   bit  no_idle;
   int  rsp_stall_request, rsp_stall_left;

   // Gain terms are Q.8 products truncated toward zero, as signed division does.
   function automatic longint q8_term(int gain, longint value);
      return (longint'(gain) * value) / longint'(1 << FRAC_W);
   endfunction

   function automatic int pwm_duty(longint mag, int blank);
      longint d;
      d = ((mag + longint'(blank)) * longint'(output_gain)) / longint'(1 << FRAC_W);
      if (d > longint'(DUTY_MAX))
         d = longint'(DUTY_MAX);
      return int'(d);
   endfunction

   function automatic void reset_loop_state();
      prop_gain   = int'(PROP_GAIN_RST);
      integ_gain  = int'(INTEG_GAIN_RST);
      deriv_gain  = int'(DERIV_GAIN_RST);
      drive_limit = int'(DRIVE_LIMIT_RST);
      dead_zone   = int'(DEAD_ZONE_RST);
      blank_fwd   = int'(BLANK_FWD_RST);
      blank_rev   = int'(BLANK_REV_RST);
      output_gain = int'(OUTPUT_GAIN_RST);
      enc_pos     = 0;
      err_now     = ERR_RESET;
      err_last    = ERR_RESET;
      err_before  = ERR_RESET;
      control_now = 0;
      duty_fwd    = 0;
      duty_rev    = 0;
   endfunction

   function automatic void set_register(logic [CSR_IDX_W-1:0] idx,
                                        logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_PROP_GAIN:     prop_gain   = int'(data[GAIN_W-1:0]);
         CSR_INTEG_GAIN:    integ_gain  = int'(data[GAIN_W-1:0]);
         CSR_DERIV_GAIN:    deriv_gain  = int'(data[GAIN_W-1:0]);
         CSR_DRIVE_LIMIT:   drive_limit = int'(data[LIMIT_W-1:0]);
         CSR_DEAD_ZONE:     dead_zone   = int'(data[DZONE_W-1:0]);
         CSR_BLANK_FORWARD: blank_fwd   = int'(data[BLANK_W-1:0]);
         CSR_BLANK_REVERSE: blank_rev   = int'(data[BLANK_W-1:0]);
         CSR_OUTPUT_GAIN:   output_gain = int'(data[OGAIN_W-1:0]);
         default: ;
      endcase
   endfunction

   // One loop step: move the position or run the PID update, then refresh one
   // duty from the drive value, and return the response it produces.
   function automatic rsp_item_type advance_loop(op_type op, logic level);
      longint       sum;
      longint       drive;
      longint       offset;
      int           mag;
      rsp_item_type r;
      if (op == OP_PULSE) begin
         enc_pos += level ? 1 : -1;
         if (enc_pos >= POS_WRAP || enc_pos <= -POS_WRAP) begin
            enc_pos = 0;
            wrap_count++;
         end
      end else begin
         err_before = err_last;
         err_last   = err_now;
         err_now    = (enc_pos % ERR_MOD) - SET_POINT;
         sum = q8_term(prop_gain, longint'(err_now) - err_last)
             + q8_term(integ_gain, longint'(err_now))
             + q8_term(deriv_gain, longint'(err_now) - 2 * longint'(err_last) + err_before);
         sum = (sum / CTRL_DIV) * CTRL_MUL;
         if (sum > longint'(CTRL_MAX))
            sum = longint'(CTRL_MAX);
         if (sum < -longint'(CTRL_MAX))
            sum = -longint'(CTRL_MAX);
         control_now = sum;
      end
      drive = -(control_now + longint'(DRIVE_BIAS));
      if (drive > longint'(drive_limit))
         drive = longint'(drive_limit);
      if (drive < -longint'(drive_limit))
         drive = -longint'(drive_limit);
      offset = longint'(SET_POINT + enc_pos);
      if (offset < 0)
         offset = -offset;
      // Near the set point the drive is forced to zero, which picks the
      // forward duty with no magnitude.
      if (offset <= longint'(dead_zone))
         drive = 0;
      if (drive >= 0)
         duty_fwd = pwm_duty(drive, blank_fwd);
      else
         duty_rev = pwm_duty(-drive, blank_rev);
      mag = enc_pos < 0 ? -enc_pos : enc_pos;
      r.position      = POS_W'(enc_pos);
      r.control_value = CTRL_W'(control_now);
      r.duty_forward  = DUTY_W'(duty_fwd);
      r.duty_reverse  = DUTY_W'(duty_rev);
      r.drive_enable  = (mag >= EN_LOW && mag <= EN_HIGH);
      return r;
   endfunction

   // Offers one request after a random gap and predicts its response once the
   // block takes it.
   task automatic send_item(op_type op, logic level);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.operation     <= op;
      req_ch.encoder_level <= level;
      do @(posedge clock); while (!req_ch.ready);
      pending_rsp.push_back(advance_loop(op, level));
      if (op == OP_TICK)
         tick_count++;
      else
         pulse_count++;
   endtask

   // Stops offering requests and waits until every response is back.
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      set_register(idx, data);
      write_count++;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic load_registers(logic [CSR_DATA_W-1:0] kp, logic [CSR_DATA_W-1:0] ki,
                                 logic [CSR_DATA_W-1:0] kd, logic [CSR_DATA_W-1:0] lim,
                                 logic [CSR_DATA_W-1:0] dz, logic [CSR_DATA_W-1:0] bf,
                                 logic [CSR_DATA_W-1:0] br, logic [CSR_DATA_W-1:0] og);
      write_reg(CSR_PROP_GAIN, kp);
      write_reg(CSR_INTEG_GAIN, ki);
      write_reg(CSR_DERIV_GAIN, kd);
      write_reg(CSR_DRIVE_LIMIT, lim);
      write_reg(CSR_DEAD_ZONE, dz);
      write_reg(CSR_BLANK_FORWARD, bf);
      write_reg(CSR_BLANK_REVERSE, br);
      write_reg(CSR_OUTPUT_GAIN, og);
   endtask

   // Zero, the register's top value, or any 12-bit pattern (upper bits masked).
   function automatic logic [CSR_DATA_W-1:0] pick_reg_value(int width);
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return CSR_DATA_W'((1 << width) - 1);
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   // Straight after reset: the preset errors feed the first ticks, and the
   // position steps both ways around zero.
   task automatic test_reset_state();
      send_item(OP_TICK, 1'b0);
      send_item(OP_PULSE, 1'b1);
      send_item(OP_PULSE, 1'b1);
      send_item(OP_PULSE, 1'b0);
      send_item(OP_TICK, 1'b1);
      send_item(OP_PULSE, 1'b0);
      send_item(OP_PULSE, 1'b0);
      send_item(OP_TICK, 1'b0);
      wait_idle();
   endtask

   // Every register at its top value, then at zero, then writes to indexes past
   // the register list, which must change nothing; then the defaults are loaded back.
   task automatic test_register_extremes();
      load_registers('1, '1, '1, '1, '1, '1, '1, '1);
      send_item(OP_TICK, 1'b1);
      send_item(OP_PULSE, 1'b1);
      send_item(OP_TICK, 1'b0);
      send_item(OP_PULSE, 1'b0);
      send_item(OP_TICK, 1'b1);
      wait_idle();
      load_registers('0, '0, '0, '0, '0, '0, '0, '0);
      send_item(OP_TICK, 1'b0);
      send_item(OP_PULSE, 1'b0);
      send_item(OP_TICK, 1'b1);
      wait_idle();
      write_reg(CSR_IDX_W'(CSR_OUTPUT_GAIN + 1), CSR_DATA_W'($urandom));
      write_reg('1, CSR_DATA_W'($urandom));
      send_item(OP_TICK, 1'b0);
      send_item(OP_PULSE, 1'b1);
      wait_idle();
      load_registers(CSR_DATA_W'(PROP_GAIN_RST), CSR_DATA_W'(INTEG_GAIN_RST),
                     CSR_DATA_W'(DERIV_GAIN_RST), CSR_DATA_W'(DRIVE_LIMIT_RST),
                     CSR_DATA_W'(DEAD_ZONE_RST), CSR_DATA_W'(BLANK_FWD_RST),
                     CSR_DATA_W'(BLANK_REV_RST), CSR_DATA_W'(OUTPUT_GAIN_RST));
   endtask

   // Walks the position down into the negative enable window with the default
   // registers, then on past the set point and out of the window with the widest
   // dead zone and drive limit, ticking on the way so the enable window is crossed
   // under control and ticks also land inside the dead zone.
   task automatic test_position_sweep();
      int spacing;
      int n;
      spacing = $urandom_range(10, 40);
      n       = 0;
      while (enc_pos > -(SET_POINT - 20)) begin
         n++;
         if (n % spacing == 0)
            send_item(OP_TICK, 1'($urandom));
         else
            send_item(OP_PULSE, 1'b0);
      end
      wait_idle();
      write_reg(CSR_DEAD_ZONE, '1);
      write_reg(CSR_DRIVE_LIMIT, '1);
      spacing = $urandom_range(10, 40);
      n       = 0;
      while (enc_pos > -(EN_HIGH + 20)) begin
         n++;
         if (n % spacing == 0)
            send_item(OP_TICK, 1'($urandom));
         else
            send_item(OP_PULSE, 1'b0);
      end
      wait_idle();
      write_reg(CSR_DEAD_ZONE, CSR_DATA_W'(DEAD_ZONE_RST));
      write_reg(CSR_DRIVE_LIMIT, CSR_DATA_W'(DRIVE_LIMIT_RST));
   endtask

   // The receiver holds off for a long stretch while requests keep coming, so
   // the response queue fills and the block must stall its request side.
   task automatic test_backpressure();
      no_idle           = 1'b1;
      rsp_stall_request = STALL_CYCLES;
      repeat (40)
         send_item(($urandom_range(0, 99) < 30) ? OP_TICK : OP_PULSE, 1'($urandom));
      no_idle = 1'b0;
      wait_idle();
   endtask

   // Phases with fresh register settings: the position wanders from where the
   // earlier tests left it, drifting one way or the other, with ticks mixed in.
   task automatic test_random_walk();
      int up_pct;
      for (int phase = 0; phase < 4; phase++) begin
         wait_idle();
         load_registers(pick_reg_value(GAIN_W), pick_reg_value(GAIN_W),
                        pick_reg_value(GAIN_W), pick_reg_value(LIMIT_W),
                        pick_reg_value(DZONE_W), pick_reg_value(BLANK_W),
                        pick_reg_value(BLANK_W), pick_reg_value(OGAIN_W));
         no_idle = (phase == 2);
         up_pct  = $urandom_range(30, 70);
         repeat (110) begin
            if ($urandom_range(0, 99) < 25)
               send_item(OP_TICK, 1'($urandom));
            else
               send_item(OP_PULSE, $urandom_range(0, 99) < up_pct);
         end
         no_idle = 1'b0;
      end
      wait_idle();
   endtask

   task automatic compare_response(rsp_item_type want);
      rsp_count++;
      if (rsp_ch.drive_enable === 1'b1)
         enabled_count++;
      if (rsp_ch.position !== want.position) begin
         fail_count++;
         $error("position: expected %0d, got %0d", want.position, rsp_ch.position);
      end
      if (rsp_ch.control_value !== want.control_value) begin
         fail_count++;
         $error("control_value: expected %0d, got %0d",
                want.control_value, rsp_ch.control_value);
      end
      if (rsp_ch.duty_forward !== want.duty_forward) begin
         fail_count++;
         $error("duty_forward: expected %0d, got %0d", want.duty_forward, rsp_ch.duty_forward);
      end
      if (rsp_ch.duty_reverse !== want.duty_reverse) begin
         fail_count++;
         $error("duty_reverse: expected %0d, got %0d", want.duty_reverse, rsp_ch.duty_reverse);
      end
      if (rsp_ch.drive_enable !== want.drive_enable) begin
         fail_count++;
         $error("drive_enable: expected %0d, got %0d", want.drive_enable, rsp_ch.drive_enable);
      end
   endtask

   // Every response handshake is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            fail_count++;
            $error("response arrived with no request outstanding");
         end else begin
            compare_response(pending_rsp.pop_front());
         end
      end
   end

   // Receiver: random hold-offs, a long counted stall on request, or none at
   // all during the steady stretches.
   always @(negedge clock) begin
      if (rsp_stall_request > 0) begin
         rsp_stall_left    = rsp_stall_request;
         rsp_stall_request = 0;
      end
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.operation     = OP_PULSE;
      req_ch.encoder_level = 1'b0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = CSR_PROP_GAIN;
      csr_ch.data          = '0;
      reset_loop_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_register_extremes();
      test_position_sweep();
      test_backpressure();
      test_random_walk();
      wait_idle();

      $display("Checked %0d responses to %0d pulses and %0d ticks in %0d cycles.",
               rsp_count, pulse_count, tick_count, cycle_count);
      $display("Made %0d register writes; saw %0d wraps and %0d drive-enabled responses.",
               write_count, wrap_count, enabled_count);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/epd_pkg.sv
src/epd_ifs.sv
src/encoder_pid_pwm_drive_top.sv
src/epd_chk.sv
tb/tb_top.sv
